// ===== hdl/set_pkg.sv =====
`timescale 1ns / 1ps

package set_pkg;

    localparam int unsigned VTX_W    = 15;
    localparam int unsigned WEIGHT_W = 31;
    localparam int unsigned KEY_W    = 2 * VTX_W;
    localparam int unsigned VCNT_W   = 16;
    localparam logic [VCNT_W-1:0] VCNT_RESET = 16'd32768;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_INSERTED   = 3'd0,
        ST_DELETED    = 3'd1,
        ST_FULL       = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_DUMP_ENTRY = 3'd4,
        ST_DUMP_EMPTY = 3'd5
    } t_status;

    // One stored edge; {src, dst} forms the sort key.
    typedef struct packed {
        logic [VTX_W-1:0]    src;
        logic [VTX_W-1:0]    dst;
        logic [WEIGHT_W-1:0] weight;
    } t_edge;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic             eval;
        logic [KEY_W-1:0] key;
        t_cell_op         op;
    } t_cell_ctl;

endpackage

// ===== hdl/set_cell.sv =====
`timescale 1ns / 1ps

module set_cell (
    input  logic             i_clk,
    input  set_pkg::t_cell_ctl i_ctl,
    input  set_pkg::t_edge   i_new,
    input  set_pkg::t_edge   i_left,
    input  set_pkg::t_edge   i_right,
    input  set_pkg::t_edge   i_wrap,
    input  logic             i_in_use,
    input  logic             i_is_tail,
    input  logic             i_prev_after,
    output set_pkg::t_edge   o_entry,
    output logic             o_after,
    output logic             o_hit
);
    import set_pkg::*;

    t_edge r_entry;
    t_edge n_entry;
    logic  r_after;
    logic  r_hit;

    // The after flag marks this cell as at or past the insert/delete position.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.eval) begin
            r_after <= !i_in_use || ({r_entry.src, r_entry.dst} >= i_ctl.key);
            r_hit   <= i_in_use && ({r_entry.src, r_entry.dst} == i_ctl.key);
        end
    end

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.op)
            CELL_HOLD: n_entry = r_entry;
            CELL_INS: begin
                if (i_prev_after) begin
                    n_entry = i_left;
                end else if (r_after) begin
                    n_entry = i_new;
                end
            end
            CELL_DEL: begin
                if (r_after) begin
                    n_entry = i_right;
                end
            end
            CELL_ROT: n_entry = i_is_tail ? i_wrap : i_right;
            default:  n_entry = r_entry;
        endcase
    end

    assign o_entry = r_entry;
    assign o_after = r_after;
    assign o_hit   = r_hit;

endmodule

// ===== hdl/sorted_edge_table.sv =====
`timescale 1ns / 1ps
// Channel  Dir  tdata (low bit up)                  tuser     tlast
// s        in   src[14:0] dst[29:15] weight[60:30]  opcode    -
// m        out  src[14:0] dst[29:15] weight[60:30]  status    last
// cfg      in   vertex_count[15:0]                  -         -
//
// Insert and delete: the accept cycle latches a compare flag in every cell
// of the chain; the apply state then shifts the chain and loads the result.
// A dump rotates the chain once per cycle, except while a qualifying edge
// waits on a full output register; one qualifying edge is held back so the
// final beat can carry last.
// Reset (synchronous, active low) empties the table; entry contents are kept.
// A full output register stalls the apply or dump step; input waits meanwhile.

module sorted_edge_table #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // src, dst, weight, zero fill
    input  logic [1:0]  i_s_tuser,   // opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // out_src, out_dst, out_weight, zero fill
    output logic [2:0]  o_m_tuser,   // status
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import set_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_APPLY = 3'b010,
        S_DUMP  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [VCNT_W-1:0] r_vertex_count;
    t_opcode           r_op, n_op;
    t_edge             r_new, n_new;
    logic              r_out_valid, n_out_valid;
    t_edge             r_out_entry, n_out_entry;
    t_status           r_out_status, n_out_status;
    logic              r_out_last, n_out_last;
    logic              r_pend_valid, n_pend_valid;
    t_edge             r_pend, n_pend;

    t_cell_ctl w_ctl;
    t_edge     w_entry [CAPACITY];
    logic      w_after [CAPACITY];
    logic      w_hit   [CAPACITY];
    logic      w_prev_after [CAPACITY];
    t_edge     w_in_edge;
    logic      w_accept;
    logic      w_out_free;
    logic      w_full;
    logic      w_found;
    logic      w_qual;

    assign w_in_edge = '{src: i_s_tdata[14:0], dst: i_s_tdata[29:15],
                         weight: i_s_tdata[60:30]};
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_qual     = ({1'b0, w_entry[0].src} < r_vertex_count);
    assign o_cfg_ready = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign w_prev_after[gi] = 1'b0;
            end else begin : g_body
                assign w_prev_after[gi] = w_after[gi-1];
            end
            set_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_new        (r_new),
                .i_left       (w_entry[(gi == 0) ? 0 : gi-1]),
                .i_right      (w_entry[(gi == CAPACITY-1) ? gi : gi+1]),
                .i_wrap       (w_entry[0]),
                .i_in_use     (CNT_W'(gi) < r_count),
                .i_is_tail    (CNT_W'(gi + 1) == r_count),
                .i_prev_after (w_prev_after[gi]),
                .o_entry      (w_entry[gi]),
                .o_after      (w_after[gi]),
                .o_hit        (w_hit[gi])
            );
        end
    endgenerate

    // A delete hits when the first cell at or past the key holds that key.
    always_comb begin
        w_found = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_found = w_found | (w_hit[i] & !w_prev_after[i]);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_op         = r_op;
        n_new        = r_new;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_entry  = r_out_entry;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        w_ctl.eval   = w_accept;
        w_ctl.key    = {w_in_edge.src, w_in_edge.dst};
        w_ctl.op     = CELL_HOLD;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_new = w_in_edge;
                    unique case (i_s_tuser)
                        OP_INSERT, OP_DELETE: begin
                            n_op    = t_opcode'(i_s_tuser);
                            n_state = S_APPLY;
                        end
                        OP_DUMP: begin
                            n_idx        = '0;
                            n_pend_valid = 1'b0;
                            n_state      = S_DUMP;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_APPLY: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_entry = '0;
                    n_out_last  = 1'b1;
                    if (r_op == OP_INSERT) begin
                        if (w_full) begin
                            n_out_status = ST_FULL;
                        end else begin
                            n_out_status = ST_INSERTED;
                            w_ctl.op     = CELL_INS;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end else begin
                        if (w_found) begin
                            n_out_status = ST_DELETED;
                            w_ctl.op     = CELL_DEL;
                            n_count      = r_count - CNT_W'(1);
                        end else begin
                            n_out_status = ST_NOT_FOUND;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (r_idx != r_count) begin
                    if (!w_qual || !r_pend_valid || w_out_free) begin
                        w_ctl.op = CELL_ROT;
                        n_idx    = r_idx + CNT_W'(1);
                        if (w_qual) begin
                            if (r_pend_valid) begin
                                n_out_valid  = 1'b1;
                                n_out_entry  = r_pend;
                                n_out_status = ST_DUMP_ENTRY;
                                n_out_last   = 1'b0;
                            end
                            n_pend       = w_entry[0];
                            n_pend_valid = 1'b1;
                        end
                    end
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_last   = 1'b1;
                    n_out_entry  = r_pend_valid ? r_pend : '0;
                    n_out_status = r_pend_valid ? ST_DUMP_ENTRY : ST_DUMP_EMPTY;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_idx          <= '0;
            r_out_valid    <= 1'b0;
            r_pend_valid   <= 1'b0;
            r_vertex_count <= VCNT_RESET;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vertex_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_new        <= n_new;
        r_out_entry  <= n_out_entry;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_pend       <= n_pend;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_entry.weight, r_out_entry.dst, r_out_entry.src};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== dv/tb_sorted_edge_table.sv =====
`timescale 1ns / 1ps

module tb_sorted_edge_table;
    import set_pkg::*;

    localparam int unsigned TABLE_DEPTH = 64;
    localparam logic [1:0]  OP_RESERVED = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned PHASE_ITEMS = 60;
    localparam int unsigned PHASE_COUNT = 8;
    localparam longint unsigned TIMEOUT_NS = 64'd10_000_000;

    typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN} t_mix;

    typedef struct packed {
        t_status             status;
        logic [VTX_W-1:0]    src;
        logic [VTX_W-1:0]    dst;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } t_beat;

    // Mirror of the edge table; every accepted command updates it and queues
    // the beats the block owes for that command.
    class edge_table_mirror;
        t_edge       slots [TABLE_DEPTH];
        int unsigned fill;
        logic [15:0] vtx_limit;
        t_beat       owed_beats [$];
        int unsigned errors;

        function new();
            fill = 0;
            vtx_limit = VCNT_RESET;
            errors = 0;
        endfunction

        function void set_vertex_count(input logic [15:0] value);
            vtx_limit = value;
        endfunction

        function void owe(input t_status st, input t_edge e, input logic lst);
            t_beat b;
            b.status = st;
            b.src    = e.src;
            b.dst    = e.dst;
            b.weight = e.weight;
            b.last   = lst;
            owed_beats.push_back(b);
        endfunction

        function bit pick_stored_key(output logic [VTX_W-1:0] s,
                                     output logic [VTX_W-1:0] d);
            int unsigned k;
            s = '0;
            d = '0;
            if (fill == 0) return 1'b0;
            k = $urandom_range(0, fill - 1);
            s = slots[k].src;
            d = slots[k].dst;
            return 1'b1;
        endfunction

        function void apply_command(input logic [1:0] op, input logic [VTX_W-1:0] s,
                                    input logic [VTX_W-1:0] d,
                                    input logic [WEIGHT_W-1:0] w);
            logic [KEY_W-1:0] key;
            int unsigned i;
            int unsigned pos;
            int unsigned n;
            bit          found;
            key = {s, d};
            if (op == OP_INSERT) begin
                if (fill >= TABLE_DEPTH) begin
                    owe(ST_FULL, '0, 1'b1);
                end else begin
                    // New edge goes ahead of any stored edge with an equal key.
                    pos = fill;
                    for (i = 0; i < fill; i++) begin
                        if ({slots[i].src, slots[i].dst} >= key) begin
                            pos = i;
                            break;
                        end
                    end
                    for (i = fill; i > pos; i--) slots[i] = slots[i-1];
                    slots[pos].src    = s;
                    slots[pos].dst    = d;
                    slots[pos].weight = w;
                    fill++;
                    owe(ST_INSERTED, '0, 1'b1);
                end
            end else if (op == OP_DELETE) begin
                found = 1'b0;
                pos = 0;
                for (i = 0; i < fill; i++) begin
                    if ({slots[i].src, slots[i].dst} == key) begin
                        pos = i;
                        found = 1'b1;
                        break;
                    end
                end
                if (found) begin
                    for (i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
                    fill--;
                    owe(ST_DELETED, '0, 1'b1);
                end else begin
                    owe(ST_NOT_FOUND, '0, 1'b1);
                end
            end else if (op == OP_DUMP) begin
                n = 0;
                for (i = 0; i < fill; i++) begin
                    if ({1'b0, slots[i].src} < vtx_limit) begin
                        owe(ST_DUMP_ENTRY, slots[i], 1'b0);
                        n++;
                    end
                end
                if (n == 0) owe(ST_DUMP_EMPTY, '0, 1'b1);
                else owed_beats[owed_beats.size()-1].last = 1'b1;
            end
        endfunction

        function void compare_beat(input logic [2:0] status, input logic [VTX_W-1:0] s,
                                   input logic [VTX_W-1:0] d,
                                   input logic [WEIGHT_W-1:0] w, input logic lst);
            t_beat want;
            if (owed_beats.size() == 0) begin
                $error("result beat arrived with nothing pending");
                errors++;
                return;
            end
            want = owed_beats.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (s !== want.src) begin
                $error("out_src: expected %0d, actual %0d", want.src, s);
                errors++;
            end
            if (d !== want.dst) begin
                $error("out_dst: expected %0d, actual %0d", want.dst, d);
                errors++;
            end
            if (w !== want.weight) begin
                $error("out_weight: expected %0d, actual %0d", want.weight, w);
                errors++;
            end
            if (lst !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [63:0] m_tdata;
    wire  [2:0]  m_tuser;
    wire         m_tlast;
    wire         cfg_ready;

    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    int unsigned rx_hold = 0;
    int unsigned rx_draw;

    edge_table_mirror table_mirror = new();

    sorted_edge_table #(
        .CAPACITY (TABLE_DEPTH)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check every taken beat, then stall for a random number of cycles.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (m_tvalid && m_tready) begin
            table_mirror.compare_beat(m_tuser, m_tdata[14:0], m_tdata[29:15],
                                      m_tdata[60:30], m_tlast);
            rx_draw = rx_calm ? 0 : $urandom_range(0, 5);
            rx_hold  <= rx_draw;
            m_tready <= (rx_draw == 0);
        end else if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_command(input logic [1:0] op, input logic [VTX_W-1:0] s,
                                input logic [VTX_W-1:0] d, input logic [WEIGHT_W-1:0] w);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, w, d, s};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        table_mirror.apply_command(op, s, d, w);
    endtask

    // Holds input off until every owed beat is in, then waits out a settle
    // period for an ignored command that may still be in flight.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (table_mirror.owed_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        table_mirror.set_vertex_count(value);
    endtask

    function automatic logic [VTX_W-1:0] pick_vertex();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return VTX_W'($urandom_range(0, 7));
        if (r < 85) return '1;
        if (r < 88) return '0;
        return VTX_W'($urandom_range(0, 32767));
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return WEIGHT_W'($urandom);
    endfunction

    task automatic random_command(input t_mix mix);
        int unsigned roll;
        int unsigned ins_pct;
        int unsigned del_pct;
        logic [1:0]          op;
        logic [VTX_W-1:0]    s;
        logic [VTX_W-1:0]    d;
        logic [WEIGHT_W-1:0] w;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                ins_pct = 80;
                del_pct = 5;
            end
            MIX_DRAIN: begin
                ins_pct = 15;
                del_pct = 65;
            end
            default: begin
                ins_pct = 45;
                del_pct = 35;
            end
        endcase
        s = pick_vertex();
        d = pick_vertex();
        w = pick_weight();
        if (roll < ins_pct) begin
            op = OP_INSERT;
        end else if (roll < ins_pct + del_pct) begin
            op = OP_DELETE;
            // Most deletes name an edge that is actually stored.
            if ($urandom_range(0, 9) < 7) void'(table_mirror.pick_stored_key(s, d));
        end else if (roll < 97) begin
            op = OP_DUMP;
        end else begin
            op = OP_RESERVED;
        end
        send_command(op, s, d, w);
    endtask

    initial begin
        logic [15:0] limits [PHASE_COUNT];
        t_mix        mixes  [PHASE_COUNT];
        int unsigned p;
        int unsigned k;

        limits = '{16'd32768, 16'd4, 16'd65535, 16'd1, 16'd0, 16'd32767,
                   16'($urandom), 16'($urandom_range(2, 12))};
        mixes  = '{MIX_BALANCED, MIX_FILL, MIX_FILL, MIX_BALANCED, MIX_DRAIN,
                   MIX_FILL, MIX_DRAIN, MIX_BALANCED};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the vertex count still at its reset value.
        send_command(OP_DUMP, '0, '0, '0);
        send_command(OP_DELETE, 15'd3, 15'd3, '0);
        send_command(OP_INSERT, '0, '0, '0);
        send_command(OP_INSERT, '1, '1, '1);
        send_command(OP_INSERT, 15'd5, 15'd7, 31'd100);
        send_command(OP_INSERT, 15'd5, 15'd7, 31'd200);
        send_command(OP_INSERT, 15'd5, 15'd3, 31'd1);
        send_command(OP_INSERT, 15'd6, '0, 31'h2AAA_AAAA);
        send_command(OP_RESERVED, '1, '1, '1);
        send_command(OP_DUMP, '1, '1, '1);
        send_command(OP_DELETE, 15'd5, 15'd7, '1);
        send_command(OP_DUMP, '0, '0, '0);
        send_command(OP_DELETE, '1, '1, '0);
        send_command(OP_DELETE, '0, '0, '0);
        send_command(OP_DELETE, '0, '0, '0);
        send_command(OP_DUMP, '0, '0, '0);

        for (p = 0; p < PHASE_COUNT; p++) begin
            drain_outputs();
            write_vertex_count(limits[p]);
            tx_calm = (p == 2) || (p == 5);
            rx_calm <= (p == 2) || (p == 6);
            for (k = 0; k < PHASE_ITEMS; k++) random_command(mixes[p]);
        end

        drain_outputs();
        if (table_mirror.errors == 0 && table_mirror.owed_beats.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
